// File: hw/rtl/mcor_pkg.sv
// ----------------------------------------------------------------------------
// mcor_pkg
// shared types and constants for the chunk offset rewriter
// ----------------------------------------------------------------------------
package mcor_pkg;

    localparam int DEF_MAX_NEST = 6;
    localparam int QUEUE_DEPTH  = 4;

    localparam logic [31:0] NAME_MOOV = 32'h6D6F6F76;
    localparam logic [31:0] NAME_STCO = 32'h7374636F;
    localparam logic [31:0] NAME_CO64 = 32'h636F3634;
    localparam logic [31:0] NAME_TRAK = 32'h7472616B;
    localparam logic [31:0] NAME_MDIA = 32'h6D646961;
    localparam logic [31:0] NAME_MINF = 32'h6D696E66;
    localparam logic [31:0] NAME_STBL = 32'h7374626C;

    // one burst of output words: cnt words taken from data, top word first
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  cnt;
        logic        changed;
        logic        last;
        logic        mal;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // expected atom name below the given nesting level on the sample table path
    function automatic logic [31:0] path_name(input logic [3:0] lvl);
        logic [31:0] nm;
        case (lvl)
            4'd1:    nm = NAME_TRAK;
            4'd2:    nm = NAME_MDIA;
            4'd3:    nm = NAME_MINF;
            4'd4:    nm = NAME_STBL;
            default: nm = 32'h0;
        endcase
        return nm;
    endfunction

endpackage

// File: hw/rtl/mcor_front.sv
// ----------------------------------------------------------------------------
// mcor_front
// atom header parser: tracks nesting, collects entries, issues output bursts
// ----------------------------------------------------------------------------
module mcor_front #(
    parameter int MAX_NEST = mcor_pkg::DEF_MAX_NEST
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output logic           o_push,
    output mcor_pkg::t_cmd o_cmd
);

    localparam int LW = $clog2(MAX_NEST + 1);
    localparam int IW = $clog2(MAX_NEST);

    typedef enum logic [2:0] {
        M_HDR,
        M_PAD,
        M_STCO_HEAD,
        M_CO64_HEAD,
        M_STCO_ENT,
        M_CO64_ENT,
        M_TRAIL
    } t_mode;

    logic [31:0]    r_stk [MAX_NEST];
    logic [LW-1:0]  r_level;
    logic [63:0]    r_hs;
    logic [3:0]     r_phase;
    t_mode          r_mode;
    logic [31:0]    r_left;
    logic [63:0]    r_buf;
    logic           r_err;

    logic [31:0]    n_stk [MAX_NEST];
    logic [LW-1:0]  n_level;
    logic [63:0]    n_hs;
    logic [3:0]     n_phase;
    t_mode          n_mode;
    logic [31:0]    n_left;
    logic [63:0]    n_buf;
    logic           n_err;
    mcor_pkg::t_cmd cmd;

    always_comb begin
        t_mode         mode;
        logic [LW-1:0] lvl_m1;
        logic [IW-1:0] top_idx;
        logic [31:0]   room;
        logic [63:0]   hs;
        logic [63:0]   nb;
        logic [31:0]   size;
        logic [31:0]   name;
        logic [31:0]   body;
        logic [31:0]   count;
        logic [31:0]   fit;
        logic [31:0]   left_d;
        logic [3:0]    esz;
        logic [LW-1:0] pl;
        t_mode         next;

        lvl_m1  = r_level - LW'(1);
        top_idx = lvl_m1[IW-1:0];
        hs      = {r_hs[55:0], i_byte};
        nb      = {r_buf[55:0], i_byte};
        size    = hs[63:32];
        name    = hs[31:0];
        body    = 32'h0;
        count   = 32'h0;
        fit     = 32'h0;
        left_d  = 32'h0;
        esz     = 4'd4;
        next    = M_PAD;
        pl      = '0;

        mode = r_mode;
        // too little left in the parent for another header
        if (r_mode == M_HDR && r_phase == 4'd0 && r_level != '0 &&
            r_stk[top_idx] < 32'd8) begin
            mode = M_PAD;
        end

        for (int i = 0; i < MAX_NEST; i++) begin
            if (i < int'(r_level) && r_stk[i] != 32'h0) begin
                n_stk[i] = r_stk[i] - 32'd1;
            end else begin
                n_stk[i] = r_stk[i];
            end
        end
        room = (r_level != '0) ? n_stk[top_idx] : 32'h0;

        n_level = r_level;
        n_hs    = r_hs;
        n_phase = r_phase;
        n_mode  = mode;
        n_left  = r_left;
        n_buf   = r_buf;
        n_err   = r_err;

        cmd.data    = {56'h0, i_byte};
        cmd.cnt     = 4'd1;
        cmd.changed = 1'b0;
        cmd.last    = 1'b0;
        cmd.mal     = 1'b0;

        case (mode)
            M_HDR: begin
                n_hs = hs;
                if (r_phase == 4'd7) begin
                    n_phase = 4'd0;
                    if (r_level == '0) begin
                        if (size < 32'd8 || name != mcor_pkg::NAME_MOOV) begin
                            n_err  = 1'b1;
                            n_mode = M_TRAIL;
                        end else begin
                            n_stk[0] = size - 32'd8;
                            n_level  = LW'(1);
                            n_mode   = M_HDR;
                        end
                    end else if (name == 32'h0) begin
                        n_mode = M_PAD;
                    end else if (size < 32'd8 || int'(r_level) >= MAX_NEST) begin
                        if (size < 32'd8) begin
                            n_err = 1'b1;
                        end
                        n_mode = M_PAD;
                    end else begin
                        body = size - 32'd8;
                        if (body > room) begin
                            n_err = 1'b1;
                            body  = room;
                        end
                        if (int'(r_level) <= 4 &&
                            name == mcor_pkg::path_name(4'(r_level))) begin
                            next = M_HDR;
                        end else if (int'(r_level) == 5 && name == mcor_pkg::NAME_STCO) begin
                            next = M_STCO_HEAD;
                        end else if (int'(r_level) == 5 && name == mcor_pkg::NAME_CO64) begin
                            next = M_CO64_HEAD;
                        end
                        if ((next == M_STCO_HEAD || next == M_CO64_HEAD) &&
                            body < 32'd8) begin
                            n_err = 1'b1;
                            next  = M_PAD;
                        end
                        n_stk[r_level[IW-1:0]] = body;
                        n_level = r_level + LW'(1);
                        n_mode  = next;
                    end
                end else begin
                    n_phase = r_phase + 4'd1;
                end
            end
            M_STCO_HEAD, M_CO64_HEAD: begin
                n_hs = hs;
                if (r_phase == 4'd7) begin
                    count = hs[31:0];
                    if (r_level != '0) begin
                        fit = (mode == M_STCO_HEAD) ? (room >> 2) : (room >> 3);
                    end
                    if (count > fit) begin
                        n_err = 1'b1;
                        count = fit;
                    end
                    n_left  = count;
                    n_phase = 4'd0;
                    n_buf   = 64'h0;
                    if (count == 32'h0) begin
                        n_mode = M_PAD;
                    end else if (mode == M_STCO_HEAD) begin
                        n_mode = M_STCO_ENT;
                    end else begin
                        n_mode = M_CO64_ENT;
                    end
                end else begin
                    n_phase = r_phase + 4'd1;
                end
            end
            M_STCO_ENT, M_CO64_ENT: begin
                esz = (mode == M_STCO_ENT) ? 4'd4 : 4'd8;
                if (r_phase + 4'd1 == esz) begin
                    // adjustment is added in the back end
                    cmd.data    = nb;
                    cmd.cnt     = esz;
                    cmd.changed = 1'b1;
                    n_phase     = 4'd0;
                    n_buf       = 64'h0;
                    left_d      = (r_left != 32'h0) ? r_left - 32'd1 : 32'h0;
                    n_left      = left_d;
                    if (left_d == 32'h0) begin
                        n_mode = M_PAD;
                    end
                end else begin
                    cmd.cnt = 4'd0;
                    n_buf   = nb;
                    n_phase = r_phase + 4'd1;
                end
            end
            default: begin
            end
        endcase

        // close every atom whose byte count has run out
        for (int i = 0; i < MAX_NEST; i++) begin
            if (i < int'(n_level) && n_stk[i] != 32'h0) begin
                pl = LW'(i + 1);
            end
        end
        if (pl != n_level) begin
            n_level = pl;
            n_mode  = (pl == '0) ? M_TRAIL : M_HDR;
            n_phase = 4'd0;
            n_left  = 32'h0;
        end

        if (i_last) begin
            if ((n_mode == M_STCO_ENT || n_mode == M_CO64_ENT) && n_phase != 4'd0) begin
                // partial entry goes out as it came in
                cmd.data    = n_buf;
                cmd.cnt     = n_phase;
                cmd.changed = 1'b0;
            end
            if (n_mode != M_TRAIL) begin
                n_err = 1'b1;
            end
            cmd.last = 1'b1;
            for (int i = 0; i < MAX_NEST; i++) begin
                n_stk[i] = 32'h0;
            end
            n_level = '0;
            n_hs    = 64'h0;
            n_phase = 4'd0;
            n_mode  = M_HDR;
            n_left  = 32'h0;
            n_buf   = 64'h0;
        end
        cmd.mal = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_NEST; i++) begin
                r_stk[i] <= 32'h0;
            end
            r_level <= '0;
            r_hs    <= 64'h0;
            r_phase <= 4'd0;
            r_mode  <= M_HDR;
            r_left  <= 32'h0;
            r_buf   <= 64'h0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_stk   <= n_stk;
            r_level <= n_level;
            r_hs    <= n_hs;
            r_phase <= n_phase;
            r_mode  <= n_mode;
            r_left  <= n_left;
            r_buf   <= n_buf;
            r_err   <= n_err;
        end
    end

    assign o_push = i_accept && (cmd.cnt != 4'd0);
    assign o_cmd  = cmd;

endmodule

// File: hw/rtl/mcor_queue.sv
// ----------------------------------------------------------------------------
// mcor_queue
// short burst queue between parser and emitter
// ----------------------------------------------------------------------------
module mcor_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mcor_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output mcor_pkg::t_cmd  o_head,
    output mcor_pkg::t_qstat o_stat
);

    localparam int PW = $clog2(mcor_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(mcor_pkg::QUEUE_DEPTH + 1);

    mcor_pkg::t_cmd r_slot [mcor_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wr;
    logic [PW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    logic do_push;
    logic do_pop;

    assign o_stat.full  = (r_cnt == CW'(mcor_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + PW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: hw/rtl/mcor_back.sv
// ----------------------------------------------------------------------------
// mcor_back
// emitter: applies the offset adjustment and sends bursts one word per ready cycle
// ----------------------------------------------------------------------------
module mcor_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [63:0]      i_adjust,
    input  mcor_pkg::t_cmd   i_head,
    input  mcor_pkg::t_qstat i_qstat,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_data,
    output logic             o_last,
    output logic             o_changed,
    output logic             o_mal
);

    logic [63:0] r_data;
    logic [3:0]  r_cnt;
    logic        r_chg;
    logic        r_last;
    logic        r_mal;

    logic        take;
    logic        load;
    logic [2:0]  sel;

    assign take = o_valid && i_ready;
    assign load = !i_qstat.empty && (r_cnt == 4'd0 || (r_cnt == 4'd1 && take));
    assign o_pop = load;

    // top word first: word cnt-1 down to word 0
    assign sel       = r_cnt[2:0] - 3'd1;
    assign o_valid   = (r_cnt != 4'd0);
    assign o_data    = r_data[{sel, 3'b000} +: 8];
    assign o_last    = r_last && (r_cnt == 4'd1);
    assign o_changed = r_chg;
    assign o_mal     = r_mal;

    always_ff @(posedge i_clk) begin
        if (load) begin
            // 64-bit wrap; an stco entry only sends its low four words
            r_data <= i_head.changed ? (i_head.data + i_adjust) : i_head.data;
            r_chg  <= i_head.changed;
            r_last <= i_head.last;
            r_mal  <= i_head.mal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 4'd0;
        end else if (load) begin
            r_cnt <= i_head.cnt;
        end else if (take) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

endmodule

// File: hw/rtl/mp4_chunk_offset_rewriter_unit.sv
// ----------------------------------------------------------------------------
// mp4_chunk_offset_rewriter_unit
// passes a moov atom through a word at a time and adjusts stco/co64 offsets
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  s_axis    in         s_axis_tvalid/tready       tdata = in_byte, tlast = in_last
//  m_axis    out        m_axis_tvalid/tready       tdata = out_byte, tlast = out_last,
//                                                  tuser = {malformed, out_changed}
//  cfg       in         i_cfg_wr_en (no wait)      i_cfg_wr_data = offset_adjust
//
//  one input word per cycle unless the queue is full; the parser updates its state in the
//  cycle a word is taken and queues a burst of 0, 1, 4 or 8 output words (up to 7 on a
//  flush); the emitter sends one word per ready cycle; an entry leaves after its last
//  word came in; s_axis_tready drops only while the four-burst queue is full
//  synchronous active-low reset clears the parser, queue, emitter and adjustment
// ----------------------------------------------------------------------------
module mp4_chunk_offset_rewriter_unit #(
    parameter int MAX_NEST = mcor_pkg::DEF_MAX_NEST
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [0] out_changed, [1] malformed
);

    logic [63:0]      r_adjust;
    logic             accept;
    logic             push;
    logic             pop;
    mcor_pkg::t_cmd   cmd;
    mcor_pkg::t_cmd   head;
    mcor_pkg::t_qstat qstat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adjust <= 64'h0;
        end else if (i_cfg_wr_en) begin
            r_adjust <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = !qstat.full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    mcor_front #(
        .MAX_NEST (MAX_NEST)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    mcor_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    mcor_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adjust  (r_adjust),
        .i_head    (head),
        .i_qstat   (qstat),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_changed (m_axis_tuser[0]),
        .o_mal     (m_axis_tuser[1])
    );

    // the parser never pushes a burst the queue cannot hold
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !qstat.full)
        else $error("burst pushed into full queue");

    // adjusted bursts are whole entries
    a_entry_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && head.changed) |-> (head.cnt == 4'd4 || head.cnt == 4'd8))
        else $error("adjusted burst of wrong length");

    // error flag stays set on every later word
    a_mal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser[1])
            |=> (!m_axis_tvalid || m_axis_tuser[1]))
        else $error("malformed flag cleared");

endmodule

// File: tb/mp4_chunk_offset_rewriter_unit_tb.sv
// ----------------------------------------------------------------------------
// mp4_chunk_offset_rewriter_unit_tb
// self-checking bench for the moov chunk offset rewriter: builds moov atoms
// along the trak/mdia/minf/stbl path with stco and co64 tables, some of them
// damaged, streams them in under several idle patterns and offset settings,
// and checks every output word against a cycle-free model of the parser
// ----------------------------------------------------------------------------
module mp4_chunk_offset_rewriter_unit_tb;

    localparam int NEST_DEPTH     = mcor_pkg::DEF_MAX_NEST;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_WORDS    = 40;

    typedef logic [7:0] t_byte_q [$];

    typedef enum logic [2:0] {
        PM_HDR,
        PM_PAD,
        PM_STCO_HEAD,
        PM_CO64_HEAD,
        PM_STCO_ENT,
        PM_CO64_ENT,
        PM_TRAIL
    } t_parse_mode;

    typedef enum int {
        FLT_BAD_NAME,
        FLT_TOP_SMALL,
        FLT_CHILD_SMALL,
        FLT_CHILD_BIG,
        FLT_NUL_NAME,
        FLT_SHORT_TABLE,
        FLT_COUNT_OVERRUN,
        FLT_TRAILING,
        FLT_EARLY_LAST,
        FLT_SHORT_TAIL
    } t_fault;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       changed;
        logic       mal;
    } t_out_word;

    typedef struct {
        int n_stco;         // -1 leaves the table out
        int n_co64;
        int count_extra;
        bit extremes;
        bit bad_top_name;
        bit top_small;
        bit child_small;
        bit child_big;
        bit nul_pad;
        bit short_table;
        bit junk;
        int tail_bytes;
        int after_bytes;
        int cut_back;
    } t_frame_plan;

    class chunk_offset_scoreboard;
        logic [63:0] adjust;
        logic [31:0] remaining [NEST_DEPTH];
        int unsigned depth;
        logic [63:0] hdr_shift;
        int unsigned phase;
        t_parse_mode mode;
        logic [31:0] entries_left;
        logic [63:0] entry_buf;
        bit          err_seen;
        logic [31:0] path_atoms [4] = '{mcor_pkg::NAME_TRAK, mcor_pkg::NAME_MDIA,
                                        mcor_pkg::NAME_MINF, mcor_pkg::NAME_STBL};
        t_out_word   burst [$];
        t_out_word   expected_words [$];
        int          errors;
        int          words_out;
        int          adjusted_out;

        function new();
            adjust       = '0;
            err_seen     = 1'b0;
            errors       = 0;
            words_out    = 0;
            adjusted_out = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            foreach (remaining[i]) remaining[i] = '0;
            depth        = 0;
            hdr_shift    = '0;
            phase        = 0;
            mode         = PM_HDR;
            entries_left = '0;
            entry_buf    = '0;
        endfunction

        function void emit(logic [7:0] data, logic changed);
            t_out_word w;
            w.data    = data;
            w.last    = 1'b0;
            w.changed = changed;
            w.mal     = 1'b0;
            burst.push_back(w);
        endfunction

        // size and name of an atom header are complete
        function void close_header();
            logic [31:0] size;
            logic [31:0] name;
            logic [31:0] body;
            logic [31:0] room;
            t_parse_mode next_mode;
            int unsigned lvl;
            size = hdr_shift[63:32];
            name = hdr_shift[31:0];
            lvl  = depth;
            if (lvl == 0) begin
                if (size < 8 || name != mcor_pkg::NAME_MOOV) begin
                    err_seen = 1'b1;
                    mode     = PM_TRAIL;
                    return;
                end
                remaining[0] = size - 8;
                depth        = 1;
                mode         = PM_HDR;
                return;
            end
            if (name == '0) begin
                mode = PM_PAD;
                return;
            end
            if (size < 8 || lvl >= NEST_DEPTH) begin
                if (size < 8) err_seen = 1'b1;
                mode = PM_PAD;
                return;
            end
            body = size - 8;
            room = remaining[lvl-1];
            if (body > room) begin
                err_seen = 1'b1;
                body     = room;
            end
            next_mode = PM_PAD;
            if (lvl <= 4 && name == path_atoms[lvl-1]) next_mode = PM_HDR;
            else if (lvl == 5 && name == mcor_pkg::NAME_STCO) next_mode = PM_STCO_HEAD;
            else if (lvl == 5 && name == mcor_pkg::NAME_CO64) next_mode = PM_CO64_HEAD;
            if ((next_mode == PM_STCO_HEAD || next_mode == PM_CO64_HEAD) && body < 8) begin
                err_seen  = 1'b1;
                next_mode = PM_PAD;
            end
            remaining[lvl] = body;
            depth          = lvl + 1;
            mode           = next_mode;
            phase          = 0;
        endfunction

        function void note_word_in(logic [7:0] b, logic last);
            int unsigned esz;
            int unsigned i;
            logic [63:0] v;
            logic [31:0] count;
            logic [31:0] fit;
            bit          popped;
            burst.delete();
            popped = 1'b0;
            if (mode == PM_HDR && phase == 0 && depth > 0 && remaining[depth-1] < 8)
                mode = PM_PAD;
            for (i = 0; i < depth && i < NEST_DEPTH; i++)
                if (remaining[i] > 0) remaining[i] = remaining[i] - 1;

            case (mode)
                PM_HDR: begin
                    emit(b, 1'b0);
                    hdr_shift = {hdr_shift[55:0], b};
                    phase++;
                    if (phase >= 8) begin
                        phase = 0;
                        close_header();
                    end
                end
                PM_STCO_HEAD, PM_CO64_HEAD: begin
                    emit(b, 1'b0);
                    hdr_shift = {hdr_shift[55:0], b};
                    phase++;
                    if (phase >= 8) begin
                        count = hdr_shift[31:0];
                        esz   = (mode == PM_STCO_HEAD) ? 4 : 8;
                        fit   = (depth > 0) ? remaining[depth-1] / esz : '0;
                        if (count > fit) begin
                            err_seen = 1'b1;
                            count    = fit;
                        end
                        entries_left = count;
                        phase        = 0;
                        entry_buf    = '0;
                        if (count == '0) mode = PM_PAD;
                        else if (mode == PM_STCO_HEAD) mode = PM_STCO_ENT;
                        else mode = PM_CO64_ENT;
                    end
                end
                PM_STCO_ENT, PM_CO64_ENT: begin
                    esz       = (mode == PM_STCO_ENT) ? 4 : 8;
                    entry_buf = {entry_buf[55:0], b};
                    phase++;
                    if (phase >= esz) begin
                        // both sums wrap at their own width
                        if (esz == 4) v = {32'h0, entry_buf[31:0] + adjust[31:0]};
                        else          v = entry_buf + adjust;
                        for (i = esz; i > 0; i--) emit(v[(i-1)*8 +: 8], 1'b1);
                        phase     = 0;
                        entry_buf = '0;
                        if (entries_left > 0) entries_left = entries_left - 1;
                        if (entries_left == '0) mode = PM_PAD;
                    end
                end
                default: emit(b, 1'b0);
            endcase

            while (depth > 0 && depth <= NEST_DEPTH && remaining[depth-1] == '0) begin
                depth--;
                mode         = PM_HDR;
                phase        = 0;
                entries_left = '0;
                popped       = 1'b1;
            end
            if (popped && depth == 0) mode = PM_TRAIL;

            if (last) begin
                // a half-collected entry goes out as it came in
                if ((mode == PM_STCO_ENT || mode == PM_CO64_ENT) && phase > 0)
                    for (i = phase; i > 0; i--) emit(entry_buf[(i-1)*8 +: 8], 1'b0);
                if (mode != PM_TRAIL) err_seen = 1'b1;
                if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
                clear_parse();
            end
            foreach (burst[k]) begin
                burst[k].mal = err_seen;
                expected_words.push_back(burst[k]);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask

        task check_word_out(t_out_word got);
            t_out_word want;
            words_out++;
            if (expected_words.size() == 0) begin
                report($sformatf("word %0d: %02h arrived with nothing outstanding",
                                 words_out, got.data));
                return;
            end
            want = expected_words.pop_front();
            if (want.changed) adjusted_out++;
            if (got.data !== want.data)
                report($sformatf("word %0d: byte %02h, wanted %02h",
                                 words_out, got.data, want.data));
            if (got.last !== want.last)
                report($sformatf("word %0d: tlast %b, wanted %b", words_out, got.last, want.last));
            if (got.changed !== want.changed)
                report($sformatf("word %0d: changed %b, wanted %b",
                                 words_out, got.changed, want.changed));
            if (got.mal !== want.mal)
                report($sformatf("word %0d: malformed %b, wanted %b",
                                 words_out, got.mal, want.mal));
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [63:0] i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;

    chunk_offset_scoreboard sb;
    int        src_idle_pct  = 0;
    int        snk_stall_pct = 0;
    int        quiet_cycles  = 0;
    int        words_in      = 0;
    int        frames_sent   = 0;
    int        adjust_writes = 0;
    t_out_word mon_word;

    mp4_chunk_offset_rewriter_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // both handshakes in one place so the model sees the input word first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_word_in(s_axis_tdata, s_axis_tlast);
                words_in++;
            end
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                mon_word.data    = m_axis_tdata;
                mon_word.last    = m_axis_tlast;
                mon_word.changed = m_axis_tuser[0];
                mon_word.mal     = m_axis_tuser[1];
                sb.check_word_out(mon_word);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    function automatic void append(ref t_byte_q q, input t_byte_q src);
        foreach (src[k]) q.push_back(src[k]);
    endfunction

    function automatic t_byte_q rand_bytes(int n);
        t_byte_q q;
        for (int k = 0; k < n; k++) q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    function automatic t_byte_q atom_header(logic [31:0] size, logic [31:0] name);
        t_byte_q q;
        for (int s = 24; s >= 0; s -= 8) q.push_back(size[s +: 8]);
        for (int s = 24; s >= 0; s -= 8) q.push_back(name[s +: 8]);
        return q;
    endfunction

    function automatic t_byte_q wrap(logic [31:0] name, t_byte_q body, int grow);
        t_byte_q q;
        q = atom_header(32'(body.size() + 8 + grow), name);
        append(q, body);
        return q;
    endfunction

    function automatic t_byte_q table_body(int esz, int n_entries, int overrun, bit extremes);
        t_byte_q     q;
        logic [31:0] count;
        int          style;
        q     = rand_bytes(4);  // version and flags
        count = 32'(n_entries + overrun);
        for (int s = 24; s >= 0; s -= 8) q.push_back(count[s +: 8]);
        for (int e = 0; e < n_entries; e++) begin
            style = extremes ? e % 2 : $urandom_range(0, 3);
            for (int k = 0; k < esz; k++) begin
                if (style == 0)      q.push_back(8'h00);
                else if (style == 1) q.push_back(8'hFF);
                else                 q.push_back(8'($urandom_range(0, 255)));
            end
        end
        return q;
    endfunction

    function automatic t_byte_q build_frame(t_frame_plan p);
        t_byte_q stbl;
        t_byte_q moov;
        t_byte_q frame;
        if (p.short_table)
            append(stbl, wrap(mcor_pkg::NAME_STCO, rand_bytes($urandom_range(0, 7)), 0));
        if (p.n_stco >= 0)
            append(stbl, wrap(mcor_pkg::NAME_STCO,
                              table_body(4, p.n_stco, p.count_extra, p.extremes), 0));
        if (p.n_co64 >= 0)
            append(stbl, wrap(mcor_pkg::NAME_CO64, table_body(8, p.n_co64, 0, p.extremes), 0));
        if (p.nul_pad) begin
            append(stbl, atom_header(32'($urandom_range(8, 16)), 32'h0));
            append(stbl, rand_bytes($urandom_range(0, 5)));
        end
        append(stbl, rand_bytes(p.tail_bytes));

        if (p.junk)
            append(moov, wrap($urandom(), rand_bytes($urandom_range(0, 6)), 0));
        append(moov, wrap(mcor_pkg::NAME_TRAK, wrap(mcor_pkg::NAME_MDIA,
               wrap(mcor_pkg::NAME_MINF, wrap(mcor_pkg::NAME_STBL, stbl, 0), 0), 0),
               p.child_big ? $urandom_range(1, 40) : 0));
        if (p.child_small) begin
            append(moov, atom_header(32'($urandom_range(0, 7)), $urandom()));
            append(moov, rand_bytes($urandom_range(0, 4)));
        end

        frame = wrap(p.bad_top_name ? $urandom() : mcor_pkg::NAME_MOOV, moov, 0);
        if (p.top_small) begin
            frame[0] = 8'h00;
            frame[1] = 8'h00;
            frame[2] = 8'h00;
            frame[3] = 8'($urandom_range(0, 7));
        end
        append(frame, rand_bytes(p.after_bytes));
        if (p.cut_back > 0 && p.cut_back < frame.size())
            frame = frame[0:frame.size()-1-p.cut_back];
        return frame;
    endfunction

    function automatic t_frame_plan base_plan(int n_stco, int n_co64);
        t_frame_plan p;
        p.n_stco       = n_stco;
        p.n_co64       = n_co64;
        p.count_extra  = 0;
        p.extremes     = 1'b0;
        p.bad_top_name = 1'b0;
        p.top_small    = 1'b0;
        p.child_small  = 1'b0;
        p.child_big    = 1'b0;
        p.nul_pad      = 1'b0;
        p.short_table  = 1'b0;
        p.junk         = 1'b0;
        p.tail_bytes   = 0;
        p.after_bytes  = 0;
        p.cut_back     = 0;
        return p;
    endfunction

    function automatic void apply_fault(ref t_frame_plan p, input t_fault f);
        case (f)
            FLT_BAD_NAME:      p.bad_top_name = 1'b1;
            FLT_TOP_SMALL:     p.top_small    = 1'b1;
            FLT_CHILD_SMALL:   p.child_small  = 1'b1;
            FLT_CHILD_BIG:     p.child_big    = 1'b1;
            FLT_NUL_NAME:      p.nul_pad      = 1'b1;
            FLT_SHORT_TABLE:   p.short_table  = 1'b1;
            FLT_COUNT_OVERRUN: p.count_extra  = $urandom_range(1, 3);
            FLT_TRAILING:      p.after_bytes  = $urandom_range(1, 6);
            FLT_EARLY_LAST:    p.cut_back     = $urandom_range(1, 12);
            FLT_SHORT_TAIL:    p.tail_bytes   = $urandom_range(1, 7);
            default:           p.junk         = 1'b1;
        endcase
    endfunction

    // random tables, with the given damage on top
    function automatic t_frame_plan random_plan(t_fault f);
        t_frame_plan p;
        p = base_plan(($urandom_range(0, 3) == 0) ? -1 : $urandom_range(0, 4),
                      ($urandom_range(0, 2) == 0) ? -1 : $urandom_range(0, 3));
        p.junk = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) p.tail_bytes = $urandom_range(1, 7);
        apply_fault(p, f);
        return p;
    endfunction

    task automatic write_adjust(logic [63:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.adjust = value;
        adjust_writes++;
    endtask

    task automatic send_frame(t_byte_q frame);
        foreach (frame[idx]) begin
            @(negedge i_clk);
            while ($urandom_range(0, 99) < src_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= frame[idx];
            s_axis_tlast  <= (idx == frame.size() - 1);
            do begin
                @(posedge i_clk);
            end while (!s_axis_tready);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;
        frames_sent++;
    endtask

    // entry words of an unfinished table leave nothing to wait for, so let it settle
    task automatic wait_drained();
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        t_fault      f;
        t_byte_q     frame;
        int          phase_words;
        int          src_pcts [4];
        int          snk_pcts [4];
        logic [63:0] phase_adjust [4];

        src_pcts     = '{0, 63, 0, 27};
        snk_pcts     = '{0, 0, 63, 27};
        // all ones carries out of every byte of an all-ones entry
        phase_adjust = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
                         64'h8000_0000_8000_0000, {$urandom(), $urandom()}};

        sb = new();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // each frame carries the next damaged shape in turn
        f = t_fault'($urandom_range(FLT_BAD_NAME, FLT_SHORT_TAIL));
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            write_adjust(phase_adjust[ph]);
            src_idle_pct  = src_pcts[ph];
            snk_stall_pct = snk_pcts[ph];
            phase_words   = 0;
            while (phase_words < PHASE_WORDS) begin
                frame = build_frame(random_plan(f));
                f     = f.next();
                phase_words += frame.size();
                send_frame(frame);
            end
        end
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        wait_drained();

        $display("ran %0d moov frames, %0d words in and %0d out, %0d of them adjusted offsets",
                 frames_sent, words_in, sb.words_out, sb.adjusted_out);
        $display("offset register written %0d times under four idle and stall patterns",
                 adjust_writes);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
